/* rtl/atm_pkg.sv */
`timescale 1ns / 1ps

package atm_pkg;

	localparam int WORD_BITS   = 32;
	localparam int ADDR_BITS   = 8;
	localparam int OPC_BITS    = 5;
	localparam int ACC_BITS    = 2;
	localparam int CFG_BITS    = 9;
	localparam int PC_OUT_BITS = 16;
	localparam int S_DATA_BITS = 48;
	localparam int M_DATA_BITS = 88;
	localparam int RESET_WORDS = 256;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [ACC_BITS-1:0] {
		K_EXEC,
		K_WRITE,
		K_READ,
		K_RESTART
	} kind_t;

	typedef enum logic [OPC_BITS-1:0] {
		OP_RET, OP_NON, OP_LFT, OP_RHT, OP_UPP, OP_DWN, OP_ADD, OP_SUB,
		OP_AND, OP_ORR, OP_XOR, OP_INC, OP_DEC, OP_ZER, OP_DBL, OP_SHL,
		OP_SHR, OP_MOV, OP_JMP, OP_JMPZ, OP_JMPNZ, OP_NJMP, OP_NJMPZ, OP_NJMPNZ,
		OP_PJMP, OP_PJMPZ, OP_PJMPNZ, OP_CALL, OP_BACK
	} op_t;

	typedef struct packed {
		kind_t                 kind;
		op_t                   op;
		logic [ADDR_BITS-1:0]  addr;
		logic [WORD_BITS-1:0]  wdata;
	} item_t;

	typedef struct packed {
		logic                  start;
		logic                  neg;
		logic [WORD_BITS-1:0]  dividend;
	} rem_req_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_EXEC,
		B_DIV,
		B_WB
	} back_state_t;

endpackage

/* rtl/atm_front.sv */
`timescale 1ns / 1ps

module atm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [atm_pkg::S_DATA_BITS-1:0] s_tdata,
	input  logic [atm_pkg::ACC_BITS-1:0]  s_tuser,
	output logic                          q_valid,
	output atm_pkg::item_t                q_item,
	input  logic                          pop
);
	import atm_pkg::*;

	localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	item_t                ent_q [QUEUE_DEPTH];
	logic [IDX_BITS-1:0]  wr_q;
	logic [IDX_BITS-1:0]  rd_q;
	logic [CNT_BITS-1:0]  count_q;
	item_t                in_item;
	logic                 push;
	logic [OPC_BITS-1:0]  opcode;

	// Opcodes past the last instruction behave as a no-op.
	always_comb begin
		opcode        = s_tdata[OPC_BITS-1:0];
		in_item.kind  = kind_t'(s_tuser);
		in_item.op    = (opcode > OPC_BITS'(OP_BACK)) ? OP_NON : op_t'(opcode);
		in_item.addr  = s_tdata[OPC_BITS +: ADDR_BITS];
		in_item.wdata = s_tdata[OPC_BITS + ADDR_BITS +: WORD_BITS];
	end

	assign s_tready = (count_q != CNT_BITS'(QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != '0);
	assign q_item   = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_q + IDX_BITS'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_q + IDX_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

endmodule

/* rtl/atm_rem.sv */
`timescale 1ns / 1ps

module atm_rem #(
	parameter int DIV_BITS = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  atm_pkg::rem_req_t    req,
	input  logic [DIV_BITS-1:0]  divisor,
	output logic                 done,
	output logic [DIV_BITS-1:0]  rem_res
);
	import atm_pkg::*;

	localparam int CNT_BITS = $clog2(WORD_BITS + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [DIV_BITS-1:0]   r_q;
	logic [DIV_BITS-1:0]   d_q;
	logic [WORD_BITS-1:0]  dvd_q;
	logic                  neg_q;
	logic [DIV_BITS:0]     trial;
	logic [DIV_BITS:0]     diff;
	logic [DIV_BITS-1:0]   step_r;

	// One quotient bit per cycle, dividend bits taken from the top down.
	always_comb begin
		trial  = {r_q, dvd_q[WORD_BITS-1]};
		diff   = trial - {1'b0, d_q};
		step_r = (trial >= {1'b0, d_q}) ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q   <= '0;
			d_q   <= divisor;
			dvd_q <= req.dividend;
			neg_q <= req.neg;
		end else if (busy_q) begin
			r_q   <= step_r;
			dvd_q <= {dvd_q[WORD_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_BITS'(1)) && !req.start;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(WORD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// A negative dividend with a nonzero remainder is folded into the range [0, d).
	assign done    = done_q;
	assign rem_res = (neg_q && (r_q != '0)) ? d_q - r_q : r_q;

endmodule

/* rtl/atm_back.sv */
`timescale 1ns / 1ps

module atm_back #(
	parameter int MEM_DEPTH = 256,
	parameter int PC_BITS   = 16,
	parameter int N_BITS    = 9
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [atm_pkg::CFG_BITS-1:0]    cfg_wdata,
	input  logic                            q_valid,
	input  atm_pkg::item_t                  q_item,
	output logic                            pop,
	output atm_pkg::rem_req_t               rem_req,
	output logic [N_BITS-1:0]               divisor,
	input  logic                            rem_done,
	input  logic [N_BITS-1:0]               rem_res,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [atm_pkg::M_DATA_BITS-1:0] m_tdata
);
	import atm_pkg::*;

	localparam int PTR_BITS = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int SUM_BITS = N_BITS + 1;
	localparam int RESET_N  = (RESET_WORDS > MEM_DEPTH) ? MEM_DEPTH : RESET_WORDS;
	localparam int TAB_SIZE = 2 ** ADDR_BITS;
	localparam int PAD_BITS = M_DATA_BITS - PC_OUT_BITS - 2 - 2 * WORD_BITS;

	back_state_t           state_q;
	back_state_t           state_d;
	item_t                 cur_q;
	logic [N_BITS-1:0]     words_q;
	logic [N_BITS-1:0]     cfg_n;
	logic [WORD_BITS-1:0]  acc_q;
	logic [PTR_BITS-1:0]   ptr_q;
	logic [PC_BITS-1:0]    pc_q;
	logic [PC_BITS-1:0]    ret_q;
	logic                  ret_valid_q;
	logic                  halt_q;
	logic                  m_tvalid_q;
	logic [M_DATA_BITS-1:0] m_tdata_q;

	logic [WORD_BITS-1:0]  mem [MEM_DEPTH];
	logic [WORD_BITS-1:0]  rdata_q;
	logic [PTR_BITS-1:0]   addr_tab [TAB_SIZE];
	logic [PTR_BITS-1:0]   mem_ra;
	logic                  mem_we;
	logic [PTR_BITS-1:0]   mem_wa;
	logic [WORD_BITS-1:0]  mem_wd;

	logic                  out_free;
	logic                  need_div;
	logic                  commit;
	logic [WORD_BITS-1:0]  n_acc;
	logic [PTR_BITS-1:0]   n_ptr;
	logic [PC_BITS-1:0]    n_pc;
	logic [PC_BITS-1:0]    n_ret;
	logic                  n_rv;
	logic                  n_halt;
	logic                  err;
	logic [WORD_BITS-1:0]  rd_out;
	logic [WORD_BITS-1:0]  div_dvd;
	logic                  div_neg;
	logic                  wr_cmd;
	logic [PTR_BITS-1:0]   wr_addr;
	logic [WORD_BITS-1:0]  wr_data;

	logic [PC_BITS-1:0]    pc_inc;
	logic [PC_BITS-1:0]    tgt_abs;
	logic [PC_BITS-1:0]    tgt_fwd;
	logic [PC_BITS-1:0]    tgt_bwd;
	logic                  cell_zero;
	logic [SUM_BITS-1:0]   step_v;
	logic [SUM_BITS-1:0]   step_sub;
	logic [SUM_BITS-1:0]   words_w;
	logic [WORD_BITS-1:0]  acc_mag;

	// Host addresses reduced modulo the memory depth.
	for (genvar i = 0; i < TAB_SIZE; i++) begin : g_tab
		assign addr_tab[i] = PTR_BITS'(i % MEM_DEPTH);
	end

	always_comb begin
		cfg_n = N_BITS'(MEM_DEPTH);
		if (cfg_wdata == '0) begin
			cfg_n = N_BITS'(1);
		end else if (32'(cfg_wdata) <= 32'(MEM_DEPTH)) begin
			cfg_n = N_BITS'(cfg_wdata);
		end
	end

	assign mem_ra = (q_item.kind == K_READ) ? addr_tab[q_item.addr] : ptr_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (pop) begin
			rdata_q <= mem[mem_ra];
		end
	end

	always_comb begin
		pc_inc    = pc_q + PC_BITS'(1);
		tgt_abs   = acc_q[PC_BITS-1:0];
		tgt_fwd   = pc_q + acc_q[PC_BITS-1:0];
		tgt_bwd   = pc_q - acc_q[PC_BITS-1:0];
		cell_zero = (rdata_q == '0);
		words_w   = SUM_BITS'(words_q);
		step_v    = (cur_q.op == OP_LFT) ? SUM_BITS'(ptr_q) + words_w - SUM_BITS'(1)
		                                 : SUM_BITS'(ptr_q) + SUM_BITS'(1);
		step_sub  = step_v - words_w;
		acc_mag   = acc_q[WORD_BITS-1] ? (~acc_q + WORD_BITS'(1)) : acc_q;
	end

	always_comb begin
		n_acc    = acc_q;
		n_ptr    = ptr_q;
		n_pc     = pc_q;
		n_ret    = ret_q;
		n_rv     = ret_valid_q;
		n_halt   = halt_q;
		err      = 1'b0;
		rd_out   = '0;
		need_div = 1'b0;
		div_dvd  = acc_mag;
		div_neg  = 1'b0;
		wr_cmd   = 1'b0;
		wr_addr  = ptr_q;
		wr_data  = acc_q;
		if (state_q == B_WB) begin
			n_ptr = PTR_BITS'(rem_res);
			n_pc  = pc_inc;
		end else begin
			unique case (cur_q.kind)
				K_EXEC: begin
					if (!halt_q) begin
						n_pc = pc_inc;
						unique case (cur_q.op) inside
							OP_RET: begin
								n_halt = 1'b1;
								n_pc   = pc_q;
							end
							OP_NON: ;
							OP_LFT, OP_RHT: begin
								if (step_v < words_w) begin
									n_ptr = PTR_BITS'(step_v);
								end else if (step_sub < words_w) begin
									n_ptr = PTR_BITS'(step_sub);
								end else begin
									need_div = 1'b1;
									div_dvd  = WORD_BITS'(step_v);
								end
							end
							OP_UPP: n_acc = rdata_q;
							OP_DWN: wr_cmd = 1'b1;
							OP_ADD: n_acc = acc_q + rdata_q;
							OP_SUB: n_acc = acc_q - rdata_q;
							OP_AND: n_acc = acc_q & rdata_q;
							OP_ORR: n_acc = acc_q | rdata_q;
							OP_XOR: n_acc = acc_q ^ rdata_q;
							OP_INC: n_acc = acc_q + WORD_BITS'(1);
							OP_DEC: n_acc = acc_q - WORD_BITS'(1);
							OP_ZER: n_acc = '0;
							OP_DBL, OP_SHL: n_acc = {acc_q[WORD_BITS-2:0], 1'b0};
							OP_SHR: n_acc = {acc_q[WORD_BITS-1], acc_q[WORD_BITS-1:1]};
							OP_MOV: begin
								need_div = 1'b1;
								div_neg  = acc_q[WORD_BITS-1];
							end
							OP_JMP: n_pc = tgt_abs;
							OP_JMPZ: if (cell_zero) n_pc = tgt_abs;
							OP_JMPNZ: if (!cell_zero) n_pc = tgt_abs;
							OP_NJMP: n_pc = tgt_fwd;
							OP_NJMPZ: if (cell_zero) n_pc = tgt_fwd;
							OP_NJMPNZ: if (!cell_zero) n_pc = tgt_fwd;
							OP_PJMP: n_pc = tgt_bwd;
							OP_PJMPZ: if (cell_zero) n_pc = tgt_bwd;
							OP_PJMPNZ: if (!cell_zero) n_pc = tgt_bwd;
							OP_CALL: begin
								n_ret = pc_q;
								n_rv  = 1'b1;
								n_pc  = tgt_abs;
							end
							OP_BACK: begin
								if (ret_valid_q) begin
									n_pc = ret_q + PC_BITS'(1);
									n_rv = 1'b0;
								end else begin
									n_halt = 1'b1;
									err    = 1'b1;
									n_pc   = pc_q;
								end
							end
							default: ;
						endcase
					end
				end
				K_WRITE: begin
					wr_cmd  = 1'b1;
					wr_addr = addr_tab[cur_q.addr];
					wr_data = cur_q.wdata;
				end
				K_READ: rd_out = rdata_q;
				K_RESTART: begin
					n_acc  = '0;
					n_ptr  = '0;
					n_pc   = '0;
					n_ret  = '0;
					n_rv   = 1'b0;
					n_halt = 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (q_valid) state_d = B_EXEC;
			B_EXEC: begin
				if (need_div) begin
					state_d = B_DIV;
				end else if (out_free) begin
					state_d = B_IDLE;
				end
			end
			B_DIV: if (rem_done) state_d = B_WB;
			B_WB: if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop              = (state_q == B_IDLE) && q_valid;
		rem_req.start    = (state_q == B_EXEC) && need_div;
		rem_req.neg      = div_neg;
		rem_req.dividend = div_dvd;
		commit           = out_free && (((state_q == B_EXEC) && !need_div) ||
		                                (state_q == B_WB));
		mem_we           = commit && wr_cmd;
		mem_wa           = wr_addr;
		mem_wd           = wr_data;
	end

	assign divisor = words_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_item;
		end
		if (commit) begin
			m_tdata_q <= {{PAD_BITS{1'b0}}, n_acc, rd_out, err, n_halt,
			              PC_OUT_BITS'(n_pc)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			words_q     <= N_BITS'(RESET_N);
			acc_q       <= '0;
			ptr_q       <= '0;
			pc_q        <= '0;
			ret_q       <= '0;
			ret_valid_q <= 1'b0;
			halt_q      <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				words_q <= cfg_n;
			end
			if (commit) begin
				acc_q       <= n_acc;
				ptr_q       <= n_ptr;
				pc_q        <= n_pc;
				ret_q       <= n_ret;
				ret_valid_q <= n_rv;
				halt_q      <= n_halt;
				m_tvalid_q  <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* rtl/accumulator_tape_machine.sv */
`timescale 1ns / 1ps
// Accumulator machine running against a circular data memory.
// Input words arrive on the s_ stream: s_tuser selects execute, data write, data read
// or restart, and s_tdata carries the opcode, the data address and the write word.
// Every input word produces exactly one output word on the m_ stream with the next
// fetch address, the halt flag, the error status, read data and the accumulator.
// The mem_words register is written through cfg_we and cfg_wdata; the user must
// write it only while the block is idle, since the block does not enforce this.
// An accepted word enters a two-entry queue; the execution unit pops it, reads the data
// memory and then commits into the output register, taking no new word until the
// last is committed while the queue still accepts. A mov, and a pointer step that lands
// far beyond a reduced word count, runs through a one-bit-per-cycle remainder unit.
// Reset clears the accumulator, pointer, program counter, return slot and halt flag, and
// sets mem_words to min(256, MEM_DEPTH); data memory stays undefined until written.
// When the receiver holds m_tready low the output word waits in its register, execution
// stops, and the queue fills until s_tready drops.
module accumulator_tape_machine #(
	parameter int MEM_DEPTH = 256,
	parameter int PC_BITS   = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// opcode[4:0], address[12:5], write_data[44:13], zero fill above.
	input  logic [atm_pkg::S_DATA_BITS-1:0] s_tdata,
	// access[1:0].
	input  logic [atm_pkg::ACC_BITS-1:0]    s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// next_pc[15:0], halted[16], status[17], read_data[49:18], acc_value[81:50], zero fill.
	output logic [atm_pkg::M_DATA_BITS-1:0] m_tdata,
	input  logic                            cfg_we,
	input  logic [atm_pkg::CFG_BITS-1:0]    cfg_wdata
);
	import atm_pkg::*;

	localparam int N_BITS = $clog2(MEM_DEPTH + 1);

	logic               q_valid;
	item_t              q_item;
	logic               pop;
	rem_req_t           rem_req;
	logic [N_BITS-1:0]  divisor;
	logic               rem_done;
	logic [N_BITS-1:0]  rem_res;

	atm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.pop      (pop)
	);

	atm_rem #(
		.DIV_BITS (N_BITS)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (rem_req),
		.divisor (divisor),
		.done    (rem_done),
		.rem_res (rem_res)
	);

	atm_back #(
		.MEM_DEPTH (MEM_DEPTH),
		.PC_BITS   (PC_BITS),
		.N_BITS    (N_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.rem_req   (rem_req),
		.divisor   (divisor),
		.rem_done  (rem_done),
		.rem_res   (rem_res),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
